// ===== rtl/core/fuzzy_cmeans_gray_segmenter_assert.svh =====
// Assertion macros for the fuzzy c-means segmenter.
`ifndef FUZZY_CMEANS_GRAY_SEGMENTER_ASSERT_SVH
`define FUZZY_CMEANS_GRAY_SEGMENTER_ASSERT_SVH

// Same-cycle implication.
`define FCM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fcm assertion failed");

// Next-cycle implication.
`define FCM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fcm assertion failed");

`endif

// ===== rtl/core/fcm_pkg.sv =====
`default_nettype none
package fcm_pkg;

  localparam int DEF_MAX_PIXELS = 1048576;
  localparam int DEF_CLUSTERS   = 4;
  localparam int DEF_PIXEL_BITS = 8;

  localparam int MEMB_SHIFT = 44;
  localparam int CENT_W     = 16;
  localparam int MEMB_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int ITER_W     = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_INIT0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXIT = 3'd5;

  localparam logic REQ_LOAD     = 1'b0;
  localparam logic REQ_CLASSIFY = 1'b1;

  localparam logic [CENT_W-1:0] INIT_C_RESET [4] = '{16'd8192, 16'd24576, 16'd40960, 16'd57344};
  localparam logic [15:0] TOL_RESET   = 16'd655;
  localparam logic [7:0]  MAXIT_RESET = 8'd100;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_HRD, S_HWR, S_INIT, S_PH, S_PH2,
    S_MD, S_MW, S_MWD, S_MQ, S_MQD, S_MEND,
    S_PRD, S_PWR, S_PDONE,
    S_UH, S_URD, S_U1, S_U2, S_U3, S_U4, S_UDIV, S_UDW,
    S_FIN
  } state_t;

  typedef enum logic [1:0] {
    MODE_CLASSIFY, MODE_PASS0, MODE_PASSI
  } mode_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/fcm_ram.sv =====
`default_nettype none
module fcm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/fcm_div.sv =====
`default_nettype none
module fcm_div #(
  parameter int DVD_W = 61,
  parameter int DVS_W = 47
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic      [DVD_W-1:0] quotient,
  output fcm_pkg::div_stat_t    stat
);
  import fcm_pkg::*;

  localparam int CW = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] q_r, q_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt, dvs_r, dvs_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt, done_r, done_nxt;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  always_comb begin
    trial    = {rem_r, q_r[DVD_W-1]};
    ge       = trial >= {1'b0, dvs_r};
    diff     = trial - {1'b0, dvs_r};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = CW'(DVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt   = {q_r[DVD_W-2:0], ge};
      rem_nxt = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient  = q_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule
`default_nettype wire

// ===== rtl/core/fuzzy_cmeans_gray_segmenter.sv =====
// Fuzzy c-means gray-level segmenter with a shared serial divider.
// Input channel (in_valid/in_ready): a load transaction adds a pixel to the
// intensity histogram; a load with in_last set then runs the clustering and
// returns one result transaction. A classify transaction returns the label
// of greatest membership and the integer part of its centroid.
// A classify needs two serial divisions per cluster for each membership, on
// a divider with a 61-bit dividend by default; a pixel on a centroid ends
// early. Clustering makes one initial membership pass over the histogram,
// then one centroid update and one membership pass per iteration.
// in_ready is high only while the sequencer is idle. The result sits in an
// output register; a new transaction may be accepted while it waits, and the
// next result is held back until the receiver has taken the previous one.
// After reset the histogram is cleared, during which no input is accepted;
// configuration writes are taken at any time.
`default_nettype none
`include "fuzzy_cmeans_gray_segmenter_assert.svh"
module fuzzy_cmeans_gray_segmenter #(
  parameter int MAX_PIXELS = fcm_pkg::DEF_MAX_PIXELS,
  parameter int CLUSTERS   = fcm_pkg::DEF_CLUSTERS,
  parameter int PIXEL_BITS = fcm_pkg::DEF_PIXEL_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        in_req_type,
  input  wire logic [PIXEL_BITS-1:0]       in_pixel,
  input  wire logic                        in_last,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [1:0]                  out_label,
  output logic      [7:0]                  out_value,
  output logic      [15:0]                 out_centroid_0,
  output logic      [15:0]                 out_centroid_1,
  output logic      [15:0]                 out_centroid_2,
  output logic      [15:0]                 out_centroid_3,
  output logic      [7:0]                  out_iterations_done,
  output logic                             out_converged,
  input  wire logic                        cfg_we,
  input  wire logic [fcm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [fcm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fcm_pkg::*;

  localparam int PIX_W   = PIXEL_BITS;
  localparam int BINS    = 1 << PIX_W;
  localparam int KW      = $clog2(CLUSTERS);
  localparam int HIST_W  = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int DIST_W  = (PIX_W + 8 > 16) ? PIX_W + 8 : 16;
  localparam int W_W     = MEMB_SHIFT + 1;
  localparam int SUM_W   = W_W + KW;
  localparam int HW_W    = HIST_W + MEMB_W;
  localparam int DEN_W   = HW_W + PIX_W;
  localparam int NUM_W   = HW_W + 2 * PIX_W;
  localparam int MA_W    = (HW_W > DIST_W) ? HW_W : DIST_W;
  localparam int MB_W    = DIST_W;
  localparam int P_W     = MA_W + MB_W;
  localparam int DVD_A   = W_W + 16;
  localparam int DVD_B   = NUM_W + 8;
  localparam int DVD_W   = (DVD_A > DVD_B) ? DVD_A : DVD_B;
  localparam int DVS_A   = (SUM_W > DEN_W) ? SUM_W : DEN_W;
  localparam int DVS_W   = (DVS_A > 2 * DIST_W) ? DVS_A : 2 * DIST_W;
  localparam int MADDR_W = KW + PIX_W;
  localparam logic [HIST_W-1:0] HIST_CAP = HIST_W'(MAX_PIXELS - 1);

  function automatic logic [CENT_W-1:0] default_init(input int k);
    return CENT_W'(((2 * k + 1) * 32768) / CLUSTERS);
  endfunction

  state_t state_r, state_nxt;
  mode_t  mode_r, mode_nxt;

  logic [CENT_W-1:0] init_c_r [4];
  logic [CENT_W-1:0] init_c_nxt [4];
  logic [15:0]       tol_r, tol_nxt;
  logic [7:0]        maxit_r, maxit_nxt;
  logic [CENT_W-1:0] cent_r [CLUSTERS];
  logic [CENT_W-1:0] cent_nxt [CLUSTERS];
  logic [W_W-1:0]    w_r [CLUSTERS];
  logic [W_W-1:0]    w_nxt [CLUSTERS];
  logic [MEMB_W-1:0] u_r [CLUSTERS];
  logic [MEMB_W-1:0] u_nxt [CLUSTERS];
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [PIX_W-1:0]  x_r, x_nxt;
  logic [KW-1:0]     k_r, k_nxt;
  logic              hnz_r, hnz_nxt;
  logic [HIST_W-1:0] h_r, h_nxt;
  logic              changed_r, changed_nxt;
  logic [NUM_W-1:0]  num_r, num_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic              conv_r, conv_nxt;
  logic              clustered_r, clustered_nxt;
  logic              in_last_r, in_last_nxt;
  logic [P_W-1:0]    mul_p_r;
  logic [MA_W-1:0]   mul_a;
  logic [MB_W-1:0]   mul_b;

  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_label_r;
  logic [7:0]        out_value_r;
  logic [CENT_W-1:0] out_cent_r [4];
  logic [ITER_W-1:0] out_iter_r;
  logic              out_conv_r;
  logic              out_load;

  logic              hist_we;
  logic [HIST_W-1:0] hist_wdata, hist_rdata;
  logic              memb_we;
  logic [MEMB_W-1:0] memb_rdata;
  logic [MADDR_W-1:0] memb_addr;

  logic              div_start;
  logic [DVD_W-1:0]  div_dvd, div_q;
  logic [DVS_W-1:0]  div_dvs;
  div_stat_t         div_stat;

  logic [DIST_W-1:0] xs_e, c_e, dabs;
  logic              k_last, x_last;
  logic [KW-1:0]     best;
  logic [MEMB_W-1:0] mdiff;
  logic [7:0]        limit;
  logic [ITER_W-1:0] iter_inc;

  fcm_ram #(.WIDTH(HIST_W), .DEPTH(BINS)) u_hist (
    .clk(clk), .we(hist_we), .waddr(x_r), .wdata(hist_wdata),
    .raddr(x_r), .rdata(hist_rdata)
  );

  fcm_ram #(.WIDTH(MEMB_W), .DEPTH(CLUSTERS * BINS)) u_memb (
    .clk(clk), .we(memb_we), .waddr(memb_addr), .wdata(u_r[k_r]),
    .raddr(memb_addr), .rdata(memb_rdata)
  );

  fcm_div #(.DVD_W(DVD_W), .DVS_W(DVS_W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dvd),
    .divisor(div_dvs), .quotient(div_q), .stat(div_stat)
  );

  assign memb_addr = {k_r, x_r};
  assign k_last    = (k_r == KW'(CLUSTERS - 1));
  assign x_last    = (x_r == {PIX_W{1'b1}});
  assign limit     = (maxit_r == 8'd0) ? 8'd1 : maxit_r;
  assign iter_inc  = iter_r + ITER_W'(1);
  assign out_load  = (state_r == S_FIN) && (!out_valid_r || out_ready);

  always_comb begin
    xs_e  = DIST_W'({x_r, 8'h00});
    c_e   = DIST_W'(cent_r[k_r]);
    dabs  = (xs_e > c_e) ? xs_e - c_e : c_e - xs_e;
    mdiff = (memb_rdata > u_r[k_r]) ? memb_rdata - u_r[k_r] : u_r[k_r] - memb_rdata;
    best  = '0;
    for (int k = 1; k < CLUSTERS; k++) begin
      if (u_r[k] > u_r[best]) begin
        best = KW'(k);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (x_last) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_req_type == REQ_CLASSIFY) ? S_MD : S_HRD;
        end
      end
      S_HRD:  state_nxt = S_HWR;
      S_HWR:  state_nxt = in_last_r ? S_INIT : S_IDLE;
      S_INIT: state_nxt = S_PH;
      S_PH:   state_nxt = S_PH2;
      S_PH2:  state_nxt = S_MD;
      S_MD:   state_nxt = (dabs == '0) ? S_MEND : S_MW;
      S_MW:   state_nxt = S_MWD;
      S_MWD:  if (div_stat.done) state_nxt = k_last ? S_MQ : S_MD;
      S_MQ:   state_nxt = S_MQD;
      S_MQD:  if (div_stat.done) state_nxt = k_last ? S_MEND : S_MQ;
      S_MEND: state_nxt = (mode_r == MODE_CLASSIFY) ? S_FIN : S_PRD;
      S_PRD:  state_nxt = S_PWR;
      S_PWR: begin
        if (!k_last) begin
          state_nxt = S_PRD;
        end else begin
          state_nxt = x_last ? S_PDONE : S_PH;
        end
      end
      S_PDONE: begin
        if (mode_r == MODE_PASS0) begin
          state_nxt = S_UH;
        end else if (!changed_r || iter_inc >= limit) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_UH;
        end
      end
      S_UH:   state_nxt = S_URD;
      S_URD:  state_nxt = S_U1;
      S_U1:   state_nxt = S_U2;
      S_U2:   state_nxt = S_U3;
      S_U3:   state_nxt = S_U4;
      S_U4:   state_nxt = x_last ? S_UDIV : S_URD;
      S_UDIV: begin
        if (den_r != '0) begin
          state_nxt = S_UDW;
        end else begin
          state_nxt = k_last ? S_PH : S_UH;
        end
      end
      S_UDW:  if (div_stat.done) state_nxt = k_last ? S_PH : S_UH;
      S_FIN:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    mode_nxt      = mode_r;
    init_c_nxt    = init_c_r;
    tol_nxt       = tol_r;
    maxit_nxt     = maxit_r;
    cent_nxt      = cent_r;
    w_nxt         = w_r;
    u_nxt         = u_r;
    sum_nxt       = sum_r;
    x_nxt         = x_r;
    k_nxt         = k_r;
    hnz_nxt       = hnz_r;
    h_nxt         = h_r;
    changed_nxt   = changed_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    iter_nxt      = iter_r;
    conv_nxt      = conv_r;
    clustered_nxt = clustered_r;
    in_last_nxt   = in_last_r;
    hist_we       = 1'b0;
    hist_wdata    = '0;
    memb_we       = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    div_start     = 1'b0;
    div_dvd       = '0;
    div_dvs       = '0;
    in_ready      = (state_r == S_IDLE);

    case (state_r)
      S_CLEAR: begin
        hist_we = 1'b1;
        x_nxt   = x_r + PIX_W'(1);
      end
      S_IDLE: begin
        if (in_valid) begin
          x_nxt       = in_pixel;
          in_last_nxt = in_last;
          k_nxt       = '0;
          sum_nxt     = '0;
          mode_nxt    = MODE_CLASSIFY;
        end
      end
      S_HWR: begin
        hist_we    = 1'b1;
        hist_wdata = (hist_rdata < HIST_CAP) ? hist_rdata + HIST_W'(1) : hist_rdata;
      end
      S_INIT: begin
        for (int k = 0; k < CLUSTERS; k++) begin
          cent_nxt[k] = (k < 4) ? init_c_r[2'(k)] : default_init(k);
        end
        x_nxt    = '0;
        k_nxt    = '0;
        mode_nxt = MODE_PASS0;
        iter_nxt = '0;
        conv_nxt = 1'b0;
      end
      S_PH2: begin
        hnz_nxt = (hist_rdata != '0);
        sum_nxt = '0;
        k_nxt   = '0;
      end
      S_MD: begin
        mul_a = MA_W'(dabs);
        mul_b = MB_W'(dabs);
        if (dabs == '0) begin
          for (int k = 0; k < CLUSTERS; k++) begin
            u_nxt[k] = '0;
          end
          u_nxt[k_r] = {MEMB_W{1'b1}};
        end
      end
      S_MW: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'(1) << MEMB_SHIFT;
        div_dvs   = DVS_W'(mul_p_r[2*DIST_W-1:0]);
      end
      S_MWD: begin
        if (div_stat.done) begin
          w_nxt[k_r] = div_q[W_W-1:0];
          sum_nxt    = sum_r + SUM_W'(div_q[W_W-1:0]);
          k_nxt      = k_last ? '0 : k_r + KW'(1);
        end
      end
      S_MQ: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'(w_r[k_r]) << 16;
        div_dvs   = DVS_W'(sum_r);
      end
      S_MQD: begin
        if (div_stat.done) begin
          u_nxt[k_r] = (|div_q[DVD_W-1:16]) ? {MEMB_W{1'b1}} : div_q[15:0];
          if (!k_last) begin
            k_nxt = k_r + KW'(1);
          end
        end
      end
      S_MEND: begin
        k_nxt = (mode_r == MODE_CLASSIFY) ? best : '0;
      end
      S_PWR: begin
        memb_we = 1'b1;
        if (mode_r == MODE_PASSI && hnz_r && mdiff >= tol_r) begin
          changed_nxt = 1'b1;
        end
        if (!k_last) begin
          k_nxt = k_r + KW'(1);
        end else begin
          k_nxt = '0;
          x_nxt = x_r + PIX_W'(1);
        end
      end
      S_PDONE: begin
        k_nxt = '0;
        if (mode_r == MODE_PASS0) begin
          changed_nxt = 1'b0;
        end else begin
          iter_nxt    = iter_inc;
          changed_nxt = 1'b0;
          if (!changed_r) begin
            conv_nxt = 1'b1;
          end
        end
      end
      S_UH: begin
        num_nxt = '0;
        den_nxt = '0;
        x_nxt   = '0;
      end
      S_U1: begin
        h_nxt = hist_rdata;
        mul_a = MA_W'(memb_rdata);
        mul_b = MB_W'(memb_rdata);
      end
      S_U2: begin
        mul_a = MA_W'(h_r);
        mul_b = MB_W'(mul_p_r[31:16]);
      end
      S_U3: begin
        den_nxt = den_r + DEN_W'(mul_p_r[HW_W-1:0]);
        mul_a   = MA_W'(mul_p_r[HW_W-1:0]);
        mul_b   = MB_W'(x_r);
      end
      S_U4: begin
        num_nxt = num_r + NUM_W'(mul_p_r[HW_W+PIX_W-1:0]);
        x_nxt   = x_r + PIX_W'(1);
      end
      S_UDIV: begin
        if (den_r != '0) begin
          div_start = 1'b1;
          div_dvd   = DVD_W'(num_r) << 8;
          div_dvs   = DVS_W'(den_r);
        end else begin
          x_nxt = '0;
          if (k_last) begin
            k_nxt    = '0;
            mode_nxt = MODE_PASSI;
          end else begin
            k_nxt = k_r + KW'(1);
          end
        end
      end
      S_UDW: begin
        if (div_stat.done) begin
          cent_nxt[k_r] = div_q[CENT_W-1:0];
          x_nxt         = '0;
          if (k_last) begin
            k_nxt    = '0;
            mode_nxt = MODE_PASSI;
          end else begin
            k_nxt = k_r + KW'(1);
          end
        end
      end
      S_FIN: begin
        if (out_load && mode_r != MODE_CLASSIFY) begin
          clustered_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (cfg_we) begin
      case (cfg_index)
        CFG_INIT0, CFG_INIT1, CFG_INIT2, CFG_INIT3: begin
          init_c_nxt[cfg_index[1:0]] = cfg_data;
          if (!clustered_r && 32'(cfg_index) < CLUSTERS) begin
            cent_nxt[KW'(cfg_index[1:0])] = cfg_data;
          end
        end
        CFG_TOL:   tol_nxt = cfg_data;
        CFG_MAXIT: maxit_nxt = cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  assign out_valid_nxt = (out_valid_r && !out_ready) || out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      mode_r      <= MODE_CLASSIFY;
      x_r         <= '0;
      k_r         <= '0;
      init_c_r    <= INIT_C_RESET;
      tol_r       <= TOL_RESET;
      maxit_r     <= MAXIT_RESET;
      for (int k = 0; k < CLUSTERS; k++) begin
        cent_r[k] <= (k < 4) ? INIT_C_RESET[2'(k)] : default_init(k);
      end
      iter_r      <= '0;
      conv_r      <= 1'b0;
      clustered_r <= 1'b0;
      changed_r   <= 1'b0;
      out_valid_r <= 1'b0;
      in_last_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      x_r         <= x_nxt;
      k_r         <= k_nxt;
      init_c_r    <= init_c_nxt;
      tol_r       <= tol_nxt;
      maxit_r     <= maxit_nxt;
      cent_r      <= cent_nxt;
      iter_r      <= iter_nxt;
      conv_r      <= conv_nxt;
      clustered_r <= clustered_nxt;
      changed_r   <= changed_nxt;
      out_valid_r <= out_valid_nxt;
      in_last_r   <= in_last_nxt;
    end
    w_r     <= w_nxt;
    u_r     <= u_nxt;
    sum_r   <= sum_nxt;
    hnz_r   <= hnz_nxt;
    h_r     <= h_nxt;
    num_r   <= num_nxt;
    den_r   <= den_nxt;
    mul_p_r <= mul_a * mul_b;
    if (out_load) begin
      out_label_r <= (mode_r == MODE_CLASSIFY) ? 2'(k_r) : 2'd0;
      out_value_r <= (mode_r == MODE_CLASSIFY) ? cent_r[k_r][15:8] : 8'd0;
      for (int k = 0; k < 4; k++) begin
        out_cent_r[k] <= (k < CLUSTERS) ? cent_r[KW'(k)] : '0;
      end
      out_iter_r <= iter_r;
      out_conv_r <= conv_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_label           = out_label_r;
  assign out_value           = out_value_r;
  assign out_centroid_0      = out_cent_r[0];
  assign out_centroid_1      = out_cent_r[1];
  assign out_centroid_2      = out_cent_r[2];
  assign out_centroid_3      = out_cent_r[3];
  assign out_iterations_done = out_iter_r;
  assign out_converged       = out_conv_r;

  `FCM_ASSERT_IMP(a_div_idle_on_start, clk, rst_n, div_start, !div_stat.busy)
  `FCM_ASSERT_IMP(a_result_from_fin, clk, rst_n, $rose(out_valid_r), $past(state_r == S_FIN))
  `FCM_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule
`default_nettype wire

// ===== tb/tb_fuzzy_cmeans_gray_segmenter.sv =====
`default_nettype none
module tb_fuzzy_cmeans_gray_segmenter;
  import fcm_pkg::*;

  localparam int   BIN_COUNT    = 256;
  localparam int   BIN_CAP      = DEF_MAX_PIXELS - 1;
  localparam int   SETTLE_CYCLES = 40;
  localparam longint CYCLE_LIMIT = 40000000;

  typedef logic [15:0] memb4_t [4];

  typedef struct {
    logic [1:0]  label;
    logic [7:0]  value;
    logic [15:0] cent [4];
    logic [7:0]  iters;
    logic        conv;
  } seg_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_req_type;
  logic [7:0]  in_pixel;
  logic        in_last;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_label;
  logic [7:0]  out_value;
  logic [15:0] out_centroid_0;
  logic [15:0] out_centroid_1;
  logic [15:0] out_centroid_2;
  logic [15:0] out_centroid_3;
  logic [7:0]  out_iterations_done;
  logic        out_converged;
  logic        cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  fuzzy_cmeans_gray_segmenter i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_req_type(in_req_type),
    .in_pixel(in_pixel), .in_last(in_last),
    .out_valid(out_valid), .out_ready(out_ready), .out_label(out_label),
    .out_value(out_value), .out_centroid_0(out_centroid_0),
    .out_centroid_1(out_centroid_1), .out_centroid_2(out_centroid_2),
    .out_centroid_3(out_centroid_3), .out_iterations_done(out_iterations_done),
    .out_converged(out_converged),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the segmenter state.
  int unsigned hist [BIN_COUNT];
  logic [15:0] prev_memb [4*BIN_COUNT];
  logic [15:0] cent [4];
  logic [15:0] init_cent [4];
  logic [15:0] tol;
  logic [7:0]  max_iter;
  logic [7:0]  iter_count;
  logic        clustered;
  logic        conv_bit;

  seg_result_t expected_results [$];
  int          mismatches;
  longint      cycles;
  bit          no_idle;
  bit          hold_req;
  int          hold_len;
  int          hold_left;
  int          stall_left;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic memb4_t membership_of(int unsigned x);
    longint unsigned xs, d, s, q;
    longint unsigned w [4];
    memb4_t u;
    xs = longint'(x) << 8;
    s = 0;
    for (int k = 0; k < 4; k++) begin
      d = (xs > cent[k]) ? xs - cent[k] : cent[k] - xs;
      if (d == 0) begin
        for (int m = 0; m < 4; m++) u[m] = '0;
        u[k] = 16'hFFFF;
        return u;
      end
      w[k] = (64'd1 << 44) / (d * d);
      s += w[k];
    end
    for (int k = 0; k < 4; k++) begin
      q = (s != 0) ? (w[k] << 16) / s : 0;
      u[k] = (q > 65535) ? 16'hFFFF : q[15:0];
    end
    return u;
  endfunction

  function automatic void move_centroids();
    longint unsigned num, den, u, hw;
    for (int k = 0; k < 4; k++) begin
      num = 0;
      den = 0;
      for (int x = 0; x < BIN_COUNT; x++) begin
        u = prev_memb[k*BIN_COUNT + x];
        hw = longint'(hist[x]) * ((u * u) >> 16);
        num += hw * x;
        den += hw;
      end
      if (den != 0) cent[k] = 16'((num << 8) / den);
    end
  endfunction

  function automatic void cluster_histogram();
    memb4_t u;
    int unsigned limit, o, diff;
    bit changed;
    limit = (max_iter != 0) ? max_iter : 1;
    for (int k = 0; k < 4; k++) cent[k] = init_cent[k];
    for (int x = 0; x < BIN_COUNT; x++) begin
      u = membership_of(x);
      for (int k = 0; k < 4; k++) prev_memb[k*BIN_COUNT + x] = u[k];
    end
    iter_count = 0;
    conv_bit = 1'b0;
    forever begin
      changed = 1'b0;
      move_centroids();
      for (int x = 0; x < BIN_COUNT; x++) begin
        u = membership_of(x);
        for (int k = 0; k < 4; k++) begin
          o = prev_memb[k*BIN_COUNT + x];
          diff = (o > u[k]) ? o - u[k] : u[k] - o;
          if (hist[x] != 0 && diff >= tol) changed = 1'b1;
          prev_memb[k*BIN_COUNT + x] = u[k];
        end
      end
      iter_count++;
      if (!changed) begin
        conv_bit = 1'b1;
        break;
      end
      if (iter_count >= limit) break;
    end
    clustered = 1'b1;
  endfunction

  function automatic void predict_segmentation(logic req, logic [7:0] pix, logic last);
    seg_result_t r;
    memb4_t u;
    int best;
    r.label = '0;
    r.value = '0;
    if (req == REQ_LOAD) begin
      if (hist[pix] < BIN_CAP) hist[pix]++;
      if (!last) return;
      cluster_histogram();
    end else begin
      u = membership_of(pix);
      best = 0;
      for (int k = 1; k < 4; k++) if (u[k] > u[best]) best = k;
      r.label = best[1:0];
      r.value = cent[best][15:8];
    end
    for (int k = 0; k < 4; k++) r.cent[k] = cent[k];
    r.iters = iter_count;
    r.conv = conv_bit;
    expected_results.push_back(r);
  endfunction

  function automatic int pick_gap();
    return no_idle ? 0 : $urandom_range(0, 12);
  endfunction

  task automatic send_item(logic req, logic [7:0] pix, logic last);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_req_type = req;
    in_pixel = pix;
    in_last = last;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_segmentation(req, pix, last);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_INIT0, CFG_INIT1, CFG_INIT2, CFG_INIT3: begin
        init_cent[idx] = data;
        if (!clustered) cent[idx] = data;
      end
      CFG_TOL:   tol = data;
      CFG_MAXIT: max_iter = data[7:0];
      default: ;
    endcase
  endtask

  task automatic test_classify_before_clustering();
    write_reg(CFG_INIT0, 16'h0000);
    write_reg(CFG_INIT3, 16'hFFFF);
    send_item(REQ_CLASSIFY, 8'd0, 1'b0);
    send_item(REQ_CLASSIFY, 8'd255, 1'b1);
    send_item(REQ_CLASSIFY, 8'd96, 1'b0);
    send_item(REQ_CLASSIFY, 8'd160, 1'b1);
    send_item(REQ_CLASSIFY, 8'd127, 1'b0);
    send_item(REQ_CLASSIFY, 8'd128, 1'b0);
    wait_idle();
  endtask

  task automatic test_directed_clustering();
    write_reg(CFG_TOL, 16'h0000);
    write_reg(CFG_MAXIT, 16'd1);
    send_item(REQ_LOAD, 8'd0, 1'b0);
    send_item(REQ_LOAD, 8'd255, 1'b0);
    send_item(REQ_LOAD, 8'd40, 1'b0);
    send_item(REQ_LOAD, 8'd40, 1'b0);
    send_item(REQ_LOAD, 8'd200, 1'b0);
    send_item(REQ_LOAD, 8'd170, 1'b1);
    send_item(REQ_CLASSIFY, 8'd0, 1'b0);
    send_item(REQ_CLASSIFY, 8'd255, 1'b0);
    send_item(REQ_CLASSIFY, 8'd100, 1'b0);
    wait_idle();
    // A write after clustering only takes effect at the next clustering.
    write_reg(CFG_INIT1, 16'h5000);
    write_reg(CFG_INIT2, 16'hA000);
    write_reg(CFG_MAXIT, 16'd0);
    send_item(REQ_CLASSIFY, 8'd80, 1'b0);
    send_item(REQ_LOAD, 8'd128, 1'b1);
    send_item(REQ_CLASSIFY, 8'd128, 1'b0);
    wait_idle();
  endtask

  task automatic test_extreme_settings();
    write_reg(CFG_TOL, 16'hFFFF);
    write_reg(CFG_MAXIT, 16'd255);
    write_reg(CFG_INIT0, 16'h1000);
    write_reg(CFG_INIT3, 16'hF000);
    send_item(REQ_LOAD, 8'd10, 1'b0);
    send_item(REQ_LOAD, 8'd250, 1'b1);
    send_item(REQ_CLASSIFY, 8'd60, 1'b0);
    wait_idle();
  endtask

  task automatic test_output_stall();
    hold_len = 3000;
    hold_req = 1'b1;
    no_idle = 1'b1;
    for (int i = 0; i < 8; i++) send_item(REQ_CLASSIFY, 8'($urandom), 1'($urandom));
    send_item(REQ_LOAD, 8'($urandom), 1'b0);
    no_idle = 1'b0;
    wait_idle();
  endtask

  task automatic test_random_segmentation();
    int loads, classifies;
    for (int phase = 0; phase < 3; phase++) begin
      for (int k = 0; k < 4; k++) write_reg(k[CFG_IDX_W-1:0], 16'($urandom));
      write_reg(CFG_TOL, (phase == 0) ? 16'($urandom_range(0, 4000)) : 16'($urandom));
      write_reg(CFG_MAXIT, 16'($urandom_range(1, 2)));
      no_idle = (phase == 1);
      loads = $urandom_range(340, 460);
      for (int i = 0; i < loads; i++) begin
        if ($urandom_range(0, 9) == 0)
          send_item(REQ_CLASSIFY, 8'($urandom), 1'($urandom));
        else
          send_item(REQ_LOAD, 8'($urandom), 1'b0);
      end
      send_item(REQ_LOAD, 8'($urandom), 1'b1);
      classifies = $urandom_range(130, 170);
      for (int i = 0; i < classifies; i++) begin
        if ($urandom_range(0, 7) == 0)
          send_item(REQ_LOAD, 8'($urandom), 1'b0);
        else
          send_item(REQ_CLASSIFY, 8'($urandom), 1'($urandom));
      end
      no_idle = 1'b0;
      wait_idle();
    end
  endtask

  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = hold_len;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else begin
      out_ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    seg_result_t e;
    bit bad;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
    if (rst_n && out_valid && out_ready) begin
      stall_left = pick_gap();
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transaction, label %0d", out_label);
      end else begin
        e = expected_results.pop_front();
        bad = (out_label !== e.label) || (out_value !== e.value)
           || (out_centroid_0 !== e.cent[0]) || (out_centroid_1 !== e.cent[1])
           || (out_centroid_2 !== e.cent[2]) || (out_centroid_3 !== e.cent[3])
           || (out_iterations_done !== e.iters) || (out_converged !== e.conv);
        if (bad) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected %0d %0d %h %h %h %h %0d %0d, got %0d %0d %h %h %h %h %0d %0d",
              e.label, e.value, e.cent[0], e.cent[1], e.cent[2], e.cent[3], e.iters, e.conv,
              out_label, out_value, out_centroid_0, out_centroid_1, out_centroid_2,
              out_centroid_3, out_iterations_done, out_converged);
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = REQ_LOAD;
    in_pixel = '0;
    in_last = 1'b0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_INIT0;
    cfg_data = '0;
    mismatches = 0;
    cycles = 0;
    no_idle = 1'b0;
    hold_req = 1'b0;
    hold_len = 0;
    hold_left = 0;
    stall_left = 0;
    for (int x = 0; x < BIN_COUNT; x++) hist[x] = 0;
    for (int i = 0; i < 4*BIN_COUNT; i++) prev_memb[i] = '0;
    for (int k = 0; k < 4; k++) begin
      init_cent[k] = INIT_C_RESET[k];
      cent[k] = INIT_C_RESET[k];
    end
    tol = TOL_RESET;
    max_iter = MAXIT_RESET;
    iter_count = '0;
    clustered = 1'b0;
    conv_bit = 1'b0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    test_classify_before_clustering();
    test_directed_clustering();
    test_extreme_settings();
    test_output_stall();
    test_random_segmentation();

    if (mismatches == 0 && expected_results.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end
endmodule
`default_nettype wire

// ===== fuzzy_cmeans_gray_segmenter.f =====
+incdir+rtl/core
rtl/core/fcm_pkg.sv
rtl/core/fcm_ram.sv
rtl/core/fcm_div.sv
rtl/core/fuzzy_cmeans_gray_segmenter.sv
tb/tb_fuzzy_cmeans_gray_segmenter.sv
